FILE: rtl/core/pidaw_pkg.sv
`default_nettype none
package pidaw_pkg;

    localparam int unsigned IDX_W = 3;

    localparam logic signed [31:0] C_DEG180  = 32'sd11796480;
    localparam logic        [31:0] C_DEG360  = 32'd23592960;
    localparam logic        [31:0] C_ERR_BIG = 32'd327680;
    localparam logic        [31:0] C_ONE     = 32'd65536;
    localparam logic        [16:0] C_UNITY   = 17'd65536;
    localparam logic        [16:0] C_LEAK    = 17'd65470;
    localparam logic        [16:0] C_WEIGHT  = 17'd19661;
    localparam logic        [16:0] C_SHRINK  = 17'd64881;

    typedef enum logic [IDX_W-1:0] {
        REG_PROP_GAIN        = 3'd0,
        REG_INTEG_GAIN       = 3'd1,
        REG_DERIV_GAIN       = 3'd2,
        REG_INTEG_BOUND      = 3'd3,
        REG_DRIVE_BOUND      = 3'd4,
        REG_ANGLE_WRAP_ON    = 3'd5,
        REG_DERIV_ON_MEASURE = 3'd6,
        REG_INTEG_DECAY_FRAC = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic signed [31:0] setpoint;
        logic signed [31:0] measured;
        logic        [16:0] time_step;
    } t_in;

    typedef struct packed {
        logic signed [31:0] drive;
        logic               saturated;
    } t_out;

    typedef struct packed {
        logic signed [31:0] prop_gain;
        logic signed [31:0] integ_gain;
        logic signed [31:0] deriv_gain;
        logic        [30:0] integ_bound;
        logic        [30:0] drive_bound;
        logic               angle_wrap_on;
        logic               deriv_on_measure;
        logic        [15:0] integ_decay_frac;
    } t_cfg;

    typedef struct packed {
        logic signed [31:0] err;
        logic signed [31:0] meas;
        logic        [16:0] dt;
    } t_item;

endpackage
`default_nettype wire

FILE: rtl/core/pid_controller_antiwindup_top.sv
`default_nettype none
// The back works on one beat at a time and holds its result while the output stalls;
// its divider for the derivative rate retires two quotient bits per cycle over a 50-bit dividend.
// The front takes a new beat while the back is still working on the previous one.
// Reset is synchronous and active low; it clears the configuration, the state machines,
// the queue pointers, the output valid and the loop state.
module pid_controller_antiwindup_top (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_in_valid,
    output logic                        o_in_stall,
    input  wire pidaw_pkg::t_in         i_in_data,
    output logic                        o_out_valid,
    input  wire logic                   i_out_stall,
    output pidaw_pkg::t_out             o_out_data,
    input  wire logic                   i_cfg_wr_en,
    input  wire logic [2:0]             i_cfg_index,
    input  wire logic [31:0]            i_cfg_data
);
    import pidaw_pkg::*;

    t_cfg  r_cfg;
    t_item front_item, queue_item;
    logic  push, pop, full, empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (t_reg_idx'(i_cfg_index))
                REG_PROP_GAIN:        r_cfg.prop_gain        <= i_cfg_data;
                REG_INTEG_GAIN:       r_cfg.integ_gain       <= i_cfg_data;
                REG_DERIV_GAIN:       r_cfg.deriv_gain       <= i_cfg_data;
                REG_INTEG_BOUND:      r_cfg.integ_bound      <= i_cfg_data[30:0];
                REG_DRIVE_BOUND:      r_cfg.drive_bound      <= i_cfg_data[30:0];
                REG_ANGLE_WRAP_ON:    r_cfg.angle_wrap_on    <= i_cfg_data[0];
                REG_DERIV_ON_MEASURE: r_cfg.deriv_on_measure <= i_cfg_data[0];
                REG_INTEG_DECAY_FRAC: r_cfg.integ_decay_frac <= i_cfg_data[15:0];
            endcase
        end
    end

    pidaw_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_in_valid),
        .o_stall         (o_in_stall),
        .i_data          (i_in_data),
        .i_angle_wrap_on (r_cfg.angle_wrap_on),
        .o_push          (push),
        .o_item          (front_item),
        .i_full          (full)
    );

    pidaw_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .o_full  (full),
        .i_pop   (pop),
        .o_item  (queue_item),
        .o_empty (empty)
    );

    pidaw_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_empty     (empty),
        .i_item      (queue_item),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule
`default_nettype wire

FILE: rtl/core/pidaw_front.sv
`default_nettype none
module pidaw_front (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_stall,
    input  wire pidaw_pkg::t_in   i_data,
    input  wire logic             i_angle_wrap_on,
    output logic                  o_push,
    output pidaw_pkg::t_item      o_item,
    input  wire logic             i_full
);
    import pidaw_pkg::*;

    typedef enum logic [2:0] {
        F_IDLE = 3'b001,
        F_WRAP = 3'b010,
        F_PUSH = 3'b100
    } t_fstate;

    t_fstate            r_state, n_state;
    logic signed [31:0] r_err, n_err;
    logic signed [31:0] r_meas, n_meas;
    logic        [16:0] r_dt, n_dt;
    logic        [31:0] r_t, n_t;
    logic               r_neg, n_neg;
    logic        [2:0]  r_step, n_step;

    logic signed [32:0] diff;
    logic signed [31:0] e_sat;
    logic signed [32:0] neg_start;
    logic        [31:0] c_step;
    logic        [31:0] t_next;

    always_comb begin
        diff = {i_data.setpoint[31], i_data.setpoint} - {i_data.measured[31], i_data.measured};
        if (diff[32] != diff[31]) begin
            e_sat = diff[32] ? 32'sh80000000 : 32'sh7fffffff;
        end else begin
            e_sat = diff[31:0];
        end
        neg_start = -{C_DEG180[31], C_DEG180} - {e_sat[31], e_sat};
        c_step = C_DEG360 << r_step;
        t_next = (r_t > c_step) ? r_t - c_step : r_t;
    end

    always_comb begin
        n_state = r_state;
        n_err   = r_err;
        n_meas  = r_meas;
        n_dt    = r_dt;
        n_t     = r_t;
        n_neg   = r_neg;
        n_step  = r_step;
        o_push  = 1'b0;
        unique case (r_state)
            F_IDLE: begin
                if (i_valid) begin
                    n_meas = i_data.measured;
                    n_dt   = (i_data.time_step == 17'd0) ? 17'd1 : i_data.time_step;
                    n_err  = e_sat;
                    n_step = 3'd6;
                    if (i_angle_wrap_on && e_sat > C_DEG180) begin
                        n_t     = 32'(e_sat - C_DEG180);
                        n_neg   = 1'b0;
                        n_state = F_WRAP;
                    end else if (i_angle_wrap_on && e_sat < -C_DEG180) begin
                        n_t     = neg_start[31:0];
                        n_neg   = 1'b1;
                        n_state = F_WRAP;
                    end else begin
                        n_state = F_PUSH;
                    end
                end
            end
            F_WRAP: begin
                n_t    = t_next;
                n_step = r_step - 3'd1;
                if (r_step == 3'd0) begin
                    n_err   = r_neg ? C_DEG180 - $signed(t_next) : $signed(t_next) - C_DEG180;
                    n_state = F_PUSH;
                end
            end
            F_PUSH: begin
                if (!i_full) begin
                    o_push  = 1'b1;
                    n_state = F_IDLE;
                end
            end
            default: n_state = F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_err  <= n_err;
        r_meas <= n_meas;
        r_dt   <= n_dt;
        r_t    <= n_t;
        r_neg  <= n_neg;
        r_step <= n_step;
    end

    assign o_stall     = (r_state != F_IDLE);
    assign o_item.err  = r_err;
    assign o_item.meas = r_meas;
    assign o_item.dt   = r_dt;

endmodule
`default_nettype wire

FILE: rtl/core/pidaw_fifo.sv
`default_nettype none
module pidaw_fifo (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire pidaw_pkg::t_item  i_item,
    output logic                   o_full,
    input  wire logic              i_pop,
    output pidaw_pkg::t_item       o_item,
    output logic                   o_empty
);
    import pidaw_pkg::*;

    t_item       r_mem [2];
    logic        r_wp, r_rp;
    logic [1:0]  r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
        if (i_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

    assign o_item  = r_mem[r_rp];
    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full) else $error("push into a full queue");
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty) else $error("pop from an empty queue");

endmodule
`default_nettype wire

FILE: rtl/core/pidaw_div.sv
`default_nettype none
module pidaw_div (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_start,
    input  wire logic [48:0]  i_num,
    input  wire logic         i_neg,
    input  wire logic [16:0]  i_den,
    output logic              o_busy,
    output logic signed [31:0] o_rate
);
    import pidaw_pkg::*;

    logic [49:0] r_num, r_quo;
    logic [16:0] r_rem, r_den;
    logic [4:0]  r_cnt;
    logic        r_busy, r_neg;

    logic [17:0] rem_a, rem_b;
    logic        ge_a, ge_b;
    logic [16:0] rem_a2, rem_b2;

    always_comb begin
        rem_a  = {r_rem, r_num[49]};
        ge_a   = rem_a >= {1'b0, r_den};
        rem_a2 = ge_a ? 17'(rem_a - {1'b0, r_den}) : rem_a[16:0];
        rem_b  = {rem_a2, r_num[48]};
        ge_b   = rem_b >= {1'b0, r_den};
        rem_b2 = ge_b ? 17'(rem_b - {1'b0, r_den}) : rem_b[16:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= 5'd0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= 5'd25;
        end else if (r_busy) begin
            r_cnt  <= r_cnt - 5'd1;
            r_busy <= (r_cnt != 5'd1);
        end
        if (i_start) begin
            r_num <= {1'b0, i_num};
            r_quo <= '0;
            r_rem <= '0;
            r_den <= i_den;
            r_neg <= i_neg;
        end else if (r_busy) begin
            r_num <= r_num << 2;
            r_quo <= {r_quo[47:0], ge_a, ge_b};
            r_rem <= rem_b2;
        end
    end

    always_comb begin
        if (!r_neg) begin
            o_rate = (r_quo > 50'h7fffffff) ? 32'sh7fffffff : $signed(r_quo[31:0]);
        end else begin
            o_rate = (r_quo > 50'h80000000) ? 32'sh80000000 : $signed(-r_quo[31:0]);
        end
    end

    assign o_busy = r_busy;

endmodule
`default_nettype wire

FILE: rtl/core/pidaw_back.sv
`default_nettype none
module pidaw_back (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire pidaw_pkg::t_cfg   i_cfg,
    input  wire logic              i_empty,
    input  wire pidaw_pkg::t_item  i_item,
    output logic                   o_pop,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output pidaw_pkg::t_out        o_out_data
);
    import pidaw_pkg::*;

    typedef enum logic [13:0] {
        S_IDLE  = 14'b00000000000001,
        S_DECAY = 14'b00000000000010,
        S_ERRDT = 14'b00000000000100,
        S_ACC   = 14'b00000000001000,
        S_LEAK  = 14'b00000000010000,
        S_LEAKW = 14'b00000000100000,
        S_WADD  = 14'b00000001000000,
        S_CLAMP = 14'b00000010000000,
        S_IGAIN = 14'b00000100000000,
        S_ISUM  = 14'b00001000000000,
        S_WDIV  = 14'b00010000000000,
        S_DSUM  = 14'b00100000000000,
        S_OUT   = 14'b01000000000000,
        S_FIN   = 14'b10000000000000
    } t_bstate;

    t_bstate            r_state, n_state;
    logic signed [31:0] r_integ_acc, r_last_err, r_last_meas;
    logic signed [31:0] r_err, r_meas;
    logic        [16:0] r_dt;
    logic signed [33:0] r_integ, n_integ;
    logic signed [49:0] r_raw, n_raw;
    logic signed [31:0] r_drv, n_drv;
    logic               r_sat, n_sat;
    logic signed [66:0] r_prod;
    logic               r_out_valid;
    t_out               r_out;

    logic signed [33:0] mul_a;
    logic signed [32:0] mul_b;
    logic               mul_en;
    logic signed [66:0] rnd;
    logic signed [50:0] rq;
    logic        [31:0] aerr;
    logic signed [32:0] diff;
    logic        [32:0] diff_mag;
    logic               div_busy;
    logic signed [31:0] rate;
    logic signed [33:0] ibnd;
    logic signed [49:0] dbnd;
    logic               hi, lo, shrink, out_free;

    assign rnd      = r_prod + 67'sd32768;
    assign rq       = rnd[66:16];
    assign aerr     = r_err[31] ? 32'(-r_err) : r_err;
    assign ibnd     = $signed({3'b0, i_cfg.integ_bound});
    assign dbnd     = $signed({19'b0, i_cfg.drive_bound});
    assign hi       = r_raw > dbnd;
    assign lo       = r_raw < -dbnd;
    assign shrink   = (hi && !r_err[31] && aerr > C_ONE) || (lo && r_err[31] && aerr > C_ONE);
    assign out_free = !r_out_valid || !i_out_stall;
    assign o_pop    = (r_state == S_IDLE) && !i_empty;

    always_comb begin
        if (i_cfg.deriv_on_measure) begin
            diff = {r_last_meas[31], r_last_meas} - {i_item.meas[31], i_item.meas};
        end else begin
            diff = {i_item.err[31], i_item.err} - {r_last_err[31], r_last_err};
        end
        diff_mag = diff[32] ? 33'(-diff) : diff;
    end

    pidaw_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (o_pop),
        .i_num   ({diff_mag, 16'b0}),
        .i_neg   (diff[32]),
        .i_den   (i_item.dt),
        .o_busy  (div_busy),
        .o_rate  (rate)
    );

    always_comb begin
        n_state = r_state;
        n_integ = r_integ;
        n_raw   = r_raw;
        n_drv   = r_drv;
        n_sat   = r_sat;
        mul_a   = r_integ;
        mul_b   = '0;
        mul_en  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (!i_empty) begin
                    n_integ = 34'(r_integ_acc);
                    n_state = S_DECAY;
                end
            end
            S_DECAY: begin
                mul_b   = $signed({16'b0, 17'(C_UNITY - {1'b0, i_cfg.integ_decay_frac})});
                mul_en  = 1'b1;
                n_state = S_ERRDT;
            end
            S_ERRDT: begin
                n_integ = rq[33:0];
                mul_a   = 34'(r_err);
                mul_b   = $signed({16'b0, r_dt});
                mul_en  = 1'b1;
                n_state = S_ACC;
            end
            S_ACC: begin
                if (aerr < C_ERR_BIG) begin
                    n_integ = r_integ + rq[33:0];
                    n_state = S_LEAK;
                end else begin
                    mul_a   = rq[33:0];
                    mul_b   = $signed({16'b0, C_WEIGHT});
                    mul_en  = 1'b1;
                    n_state = S_WADD;
                end
            end
            S_LEAK: begin
                mul_b   = $signed({16'b0, (aerr < C_ONE) ? C_LEAK : C_UNITY});
                mul_en  = 1'b1;
                n_state = S_LEAKW;
            end
            S_LEAKW: begin
                n_integ = rq[33:0];
                n_state = S_CLAMP;
            end
            S_WADD: begin
                n_integ = r_integ + rq[33:0];
                n_state = S_CLAMP;
            end
            S_CLAMP: begin
                if (r_integ > ibnd) begin
                    n_integ = ibnd;
                end else if (r_integ < -ibnd) begin
                    n_integ = -ibnd;
                end
                mul_a   = 34'(r_err);
                mul_b   = 33'(i_cfg.prop_gain);
                mul_en  = 1'b1;
                n_state = S_IGAIN;
            end
            S_IGAIN: begin
                n_raw   = rq[49:0];
                mul_b   = 33'(i_cfg.integ_gain);
                mul_en  = 1'b1;
                n_state = S_ISUM;
            end
            S_ISUM: begin
                n_raw   = r_raw + rq[49:0];
                n_state = S_WDIV;
            end
            S_WDIV: begin
                if (!div_busy) begin
                    mul_a   = 34'(rate);
                    mul_b   = 33'(i_cfg.deriv_gain);
                    mul_en  = 1'b1;
                    n_state = S_DSUM;
                end
            end
            S_DSUM: begin
                n_raw   = r_raw + rq[49:0];
                n_state = S_OUT;
            end
            S_OUT: begin
                if (hi) begin
                    n_drv = $signed({1'b0, i_cfg.drive_bound});
                end else if (lo) begin
                    n_drv = -$signed({1'b0, i_cfg.drive_bound});
                end else begin
                    n_drv = r_raw[31:0];
                end
                n_sat   = hi || lo;
                mul_b   = $signed({16'b0, shrink ? C_SHRINK : C_UNITY});
                mul_en  = 1'b1;
                n_state = S_FIN;
            end
            S_FIN: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_integ_acc <= '0;
            r_last_err  <= '0;
            r_last_meas <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_FIN && out_free) begin
                r_integ_acc <= rq[31:0];
                r_last_err  <= r_err;
                r_last_meas <= r_meas;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
        if (o_pop) begin
            r_err  <= i_item.err;
            r_meas <= i_item.meas;
            r_dt   <= i_item.dt;
        end
        if (mul_en) begin
            r_prod <= mul_a * mul_b;
        end
        if (r_state == S_FIN && out_free) begin
            r_out.drive     <= r_drv;
            r_out.saturated <= r_sat;
        end
        r_integ <= n_integ;
        r_raw   <= n_raw;
        r_drv   <= n_drv;
        r_sat   <= n_sat;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_div_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !div_busy) else $error("divider busy while idle");
    a_out_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_FIN)) else $error("result without finish");

endmodule
`default_nettype wire

FILE: verif/tb_pid_controller_antiwindup_top.sv
`timescale 1ns / 1ps
`default_nettype none
module tb_pid_controller_antiwindup_top;
    import pidaw_pkg::*;

    localparam longint DEG180 = 64'sd11796480;
    localparam longint DEG360 = 64'sd23592960;
    localparam longint ERR_BIG = 64'sd327680;
    localparam longint Q_ONE = 64'sd65536;
    localparam longint S32_MAX = 64'sd2147483647;
    localparam longint S32_MIN = -64'sd2147483648;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int SETTLE_CYCLES = 60;

    class pid_scoreboard;
        longint kp, ki, kd, integ_lim, drive_lim, decay;
        bit wrap_on, d_on_meas;
        longint integ, last_err, last_meas;
        t_out drive_q[$];
        int mismatches, beats_in, beats_out, sat_seen;

        function new();
            kp = 0; ki = 0; kd = 0; integ_lim = 0; drive_lim = 0; decay = 0;
            wrap_on = 0; d_on_meas = 0; integ = 0; last_err = 0; last_meas = 0;
            mismatches = 0; beats_in = 0; beats_out = 0; sat_seen = 0;
        endfunction

        function longint sat32(longint v);
            if (v > S32_MAX) return S32_MAX;
            if (v < S32_MIN) return S32_MIN;
            return v;
        endfunction

        function longint mulq(longint a, longint b);
            return (a * b + 64'sd32768) >>> 16;
        endfunction

        function longint clampsym(longint v, longint lim);
            if (v > lim) return lim;
            if (v < -lim) return -lim;
            return v;
        endfunction

        function void set_reg(t_reg_idx idx, logic [31:0] val);
            case (idx)
                REG_PROP_GAIN: kp = longint'(signed'(val));
                REG_INTEG_GAIN: ki = longint'(signed'(val));
                REG_DERIV_GAIN: kd = longint'(signed'(val));
                REG_INTEG_BOUND: integ_lim = longint'({33'd0, val[30:0]});
                REG_DRIVE_BOUND: drive_lim = longint'({33'd0, val[30:0]});
                REG_ANGLE_WRAP_ON: wrap_on = val[0];
                REG_DERIV_ON_MEASURE: d_on_meas = val[0];
                REG_INTEG_DECAY_FRAC: decay = longint'({48'd0, val[15:0]});
                default: ;
            endcase
        endfunction

        function void note_beat(t_in x);
            longint sp, meas, dt, err, aerr, acc, diff, rate, raw, drv, k;
            t_out res;
            sp = longint'(x.setpoint);
            meas = longint'(x.measured);
            dt = longint'({47'd0, x.time_step});
            if (dt == 0) dt = 1;
            err = sat32(sp - meas);
            if (wrap_on) begin
                if (err > DEG180) begin
                    k = (err - DEG180 + DEG360 - 1) / DEG360;
                    err -= k * DEG360;
                end else if (err < -DEG180) begin
                    k = (-DEG180 - err + DEG360 - 1) / DEG360;
                    err += k * DEG360;
                end
            end
            aerr = err < 0 ? -err : err;
            acc = integ;
            if (decay != 0) acc = mulq(acc, Q_ONE - decay);
            if (aerr < ERR_BIG) begin
                acc += mulq(err, dt);
                if (aerr < Q_ONE) acc = mulq(acc, 65470);
            end else begin
                acc += mulq(mulq(err, dt), 19661);
            end
            acc = clampsym(acc, integ_lim);
            diff = d_on_meas ? (last_meas - meas) : (err - last_err);
            rate = sat32((diff * 65536) / dt);
            raw = mulq(kp, err) + mulq(ki, acc) + mulq(kd, rate);
            drv = raw;
            res.saturated = 1'b0;
            if (raw > drive_lim) begin
                drv = drive_lim;
                res.saturated = 1'b1;
                if (err > 0 && aerr > Q_ONE) acc = mulq(acc, 64881);
            end else if (raw < -drive_lim) begin
                drv = -drive_lim;
                res.saturated = 1'b1;
                if (err < 0 && aerr > Q_ONE) acc = mulq(acc, 64881);
            end
            integ = acc;
            last_err = err;
            last_meas = meas;
            res.drive = drv[31:0];
            drive_q.push_back(res);
            beats_in++;
        endfunction

        function void check_beat(t_out got);
            t_out want;
            beats_out++;
            if (got.saturated) sat_seen++;
            if (drive_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected output beat drive=%0d sat=%0b",
                             got.drive, got.saturated);
                return;
            end
            want = drive_q.pop_front();
            if (got.drive !== want.drive || got.saturated !== want.saturated) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: beat %0d drive exp %0d got %0d, sat exp %0b got %0b",
                             beats_out, want.drive, got.drive, want.saturated,
                             got.saturated);
            end
        endfunction
    endclass

    logic i_clk, i_rst_n;
    logic i_in_valid, o_in_stall, o_out_valid, i_out_stall;
    t_in i_in_data;
    t_out o_out_data;
    logic i_cfg_wr_en;
    logic [2:0] i_cfg_index;
    logic [31:0] i_cfg_data;

    pid_scoreboard sb;
    int src_idle, sink_idle, cycles, cfg_sets;
    bit hold_go;
    int hold_left;

    pid_controller_antiwindup_top DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out_data(o_out_data),
        .i_cfg_wr_en(i_cfg_wr_en), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("tb_pid_controller_antiwindup_top NOT OK");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        if (hold_go && hold_left == 0) hold_left = 400;
        if (hold_left > 0) begin
            hold_left--;
            if (hold_left == 0) hold_go = 1'b0;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < sink_idle);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) sb.check_beat(o_out_data);
    end

    task automatic send_beat(input logic [31:0] sp, input logic [31:0] meas,
                             input logic [16:0] dt);
        t_in x;
        x.setpoint = sp;
        x.measured = meas;
        x.time_step = dt;
        @(negedge i_clk);
        while ($urandom_range(99) < src_idle) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= x;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_beat(x);
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (sb.drive_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [31:0] val);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        sb.set_reg(idx, val);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    task automatic load_cfg(input logic [31:0] kp, input logic [31:0] ki,
                            input logic [31:0] kd, input logic [31:0] ilim,
                            input logic [31:0] dlim, input logic wrap,
                            input logic dom, input logic [31:0] dec);
        write_reg(REG_PROP_GAIN, kp);
        write_reg(REG_INTEG_GAIN, ki);
        write_reg(REG_DERIV_GAIN, kd);
        write_reg(REG_INTEG_BOUND, ilim);
        write_reg(REG_DRIVE_BOUND, dlim);
        write_reg(REG_ANGLE_WRAP_ON, {31'd0, wrap});
        write_reg(REG_DERIV_ON_MEASURE, {31'd0, dom});
        write_reg(REG_INTEG_DECAY_FRAC, dec);
        cfg_sets++;
    endtask

    task automatic load_random_cfg(input int kind);
        case (kind)
            0: load_cfg(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                        32'h7fffffff, 1'b1, 1'b1, 32'h0000ffff);
            1: load_cfg(32'h80000000, 32'h80000000, 32'h80000000, 32'd0, 32'd0,
                        1'b0, 1'b0, 32'd0);
            2: load_cfg($urandom, $urandom, $urandom, $urandom, $urandom,
                        1'($urandom_range(1)), 1'($urandom_range(1)), $urandom);
            default: load_cfg($urandom_range(262144) - 131072,
                              $urandom_range(131072) - 65536,
                              $urandom_range(8192) - 4096,
                              $urandom_range(6553600), $urandom_range(655360, 100),
                              1'($urandom_range(1)), 1'($urandom_range(1)),
                              $urandom_range(3) == 0 ? $urandom_range(3000) : 0);
        endcase
    endtask

    task automatic send_random();
        logic [31:0] meas, delta;
        logic [16:0] dt;
        case ($urandom_range(9))
            0, 1: delta = $urandom_range(131072) - 65536;
            2, 3, 4: delta = $urandom_range(655360) - 327680;
            5, 6: delta = $urandom_range(47185920) - 23592960;
            default: delta = $urandom;
        endcase
        meas = ($urandom_range(3) == 0) ? $urandom : $urandom_range(47185920) - 23592960;
        case ($urandom_range(7))
            0: dt = 17'd1;
            1: dt = 17'd65536;
            2, 3: dt = 17'($urandom_range(65536, 1));
            default: dt = 17'($urandom_range(2000, 1));
        endcase
        send_beat(meas + delta, meas, dt);
    endtask

    initial begin
        sb = new();
        cycles = 0;
        cfg_sets = 0;
        hold_go = 1'b0;
        hold_left = 0;
        src_idle = 24;
        sink_idle = 75;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        i_out_stall = 1'b0;
        i_cfg_wr_en = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        load_cfg(32'd65536, 32'd32768, 32'd655, 32'd6553600, 32'd3276800,
                 1'b1, 1'b0, 32'd0);
        send_beat(32'h7fffffff, 32'h80000000, 17'd65536);
        send_beat(32'h80000000, 32'h7fffffff, 17'd1);
        send_beat(32'd0, 32'd0, 17'd1);
        send_beat(32'd30000, 32'd0, 17'd65536);
        send_beat(32'd200000, 32'd0, 17'd32768);
        send_beat(32'd400000, 32'd0, 17'd65536);
        send_beat(-32'sd400000, 32'd0, 17'd65536);
        send_beat(32'd65536, 32'd0, 17'd100);
        send_beat(32'd11796481, 32'd0, 17'd500);
        send_beat(-32'sd11796481, 32'd0, 17'd500);
        send_beat(32'd11796480, 32'd0, 17'd1);
        send_beat(32'd70000000, -32'sd70000000, 17'd1);
        send_beat(32'h7fffffff, 32'd0, 17'd1);
        drain();
        load_cfg(32'h7fffffff, 32'd65536, 32'h7fffffff, 32'd65536, 32'd0,
                 1'b0, 1'b1, 32'd65535);
        send_beat(32'd0, 32'h7fffffff, 17'd1);
        send_beat(32'd0, 32'h80000000, 17'd1);
        send_beat(32'd1000, 32'd0, 17'd65536);
        send_beat(32'd0, 32'd0, 17'd65536);
        send_beat(32'd5000000, 32'd0, 17'd2);
        send_beat(-32'sd5000000, 32'd0, 17'd2);
        send_beat(32'd65537, 32'd0, 17'd1);
        drain();

        for (int ph = 0; ph < 3; ph++) begin
            src_idle = (ph == 0) ? 24 : (ph == 1) ? 75 : 0;
            sink_idle = (ph == 0) ? 75 : (ph == 1) ? 24 : 0;
            for (int s = 0; s < 3; s++) begin
                load_random_cfg((ph * 3 + s) < 2 ? ph * 3 + s : $urandom_range(2, 5));
                if (ph == 2 && s == 0) hold_go = 1'b1;
                for (int n = 0; n < 150; n++) send_random();
                drain();
            end
        end

        $display("Sent %0d beats and checked %0d results over %0d register settings;",
                 sb.beats_in, sb.beats_out, cfg_sets);
        $display("%0d results saturated, with wrap, decay and both derivative modes.",
                 sb.sat_seen);
        if (sb.mismatches == 0 && sb.drive_q.size() == 0) begin
            $display("tb_pid_controller_antiwindup_top OK");
        end else begin
            $display("%0d mismatches, %0d results missing", sb.mismatches,
                     sb.drive_q.size());
            $display("tb_pid_controller_antiwindup_top NOT OK");
        end
        $finish;
    end
endmodule
`default_nettype wire

FILE: filelist.f
rtl/core/pidaw_pkg.sv
rtl/core/pidaw_front.sv
rtl/core/pidaw_fifo.sv
rtl/core/pidaw_div.sv
rtl/core/pidaw_back.sv
rtl/core/pid_controller_antiwindup_top.sv
verif/tb_pid_controller_antiwindup_top.sv
